// ===== rtl/ctl_pkg.sv =====
`default_nettype none

package ctl_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int TOKEN_W = 16;
    localparam int KIND_W = 3;
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_name;
    } lex_in_t;

    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [TOKEN_W-1:0] token_start;
        logic [TOKEN_W-1:0] token_length;
        logic               last_in_run;
    } token_t;

    typedef enum logic [8:0] {
        CTX_NONE    = 9'b000000001,
        CTX_IDENT   = 9'b000000010,
        CTX_NUM     = 9'b000000100,
        CTX_EXP     = 9'b000001000,
        CTX_PUNCT   = 9'b000010000,
        CTX_STR     = 9'b000100000,
        CTX_STR_ESC = 9'b001000000,
        CTX_CHR     = 9'b010000000,
        CTX_CHR_ESC = 9'b100000000
    } ctx_t;

    typedef enum logic [1:0] {
        CL_SEP    = 2'd0,
        CL_LETTER = 2'd1,
        CL_DIGIT  = 2'd2,
        CL_PUNCT  = 2'd3
    } char_class_t;

    localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PUNCT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STRING = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd4;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_E_LOWER    = 8'h65;
    localparam logic [7:0] CH_E_UPPER    = 8'h45;
    localparam logic [7:0] CH_P_LOWER    = 8'h70;
    localparam logic [7:0] CH_P_UPPER    = 8'h50;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cl;
        if (c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERSCORE}) begin
            cl = CL_LETTER;
        end else if (c inside {[8'h30:8'h39]}) begin
            cl = CL_DIGIT;
        end else if (c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96],
                               [8'd123:8'd126]}) begin
            cl = CL_PUNCT;
        end else begin
            cl = CL_SEP;
        end
        return cl;
    endfunction

    function automatic logic [KIND_W-1:0] kind_of(input ctx_t cx);
        logic [KIND_W-1:0] k;
        case (cx)
            CTX_IDENT:            k = KIND_IDENT;
            CTX_NUM, CTX_EXP:     k = KIND_NUMBER;
            CTX_PUNCT:            k = KIND_PUNCT;
            CTX_STR, CTX_STR_ESC: k = KIND_STRING;
            default:              k = KIND_CHAR;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ctl_step.sv =====
`default_nettype none

module ctl_step
    import ctl_pkg::*;
#(
    parameter int POS_W = POSITION_BITS_DEFAULT
) (
    input  ctx_t             ctx,
    input  logic [POS_W-1:0] pos,
    input  logic [POS_W-1:0] open_start,
    input  logic [POS_W-1:0] open_len,
    input  lex_in_t          din,
    output ctx_t             ctx_next,
    output logic [POS_W-1:0] pos_next,
    output logic [POS_W-1:0] start_next,
    output logic [POS_W-1:0] len_next,
    output token_t           res0,
    output token_t           res1,
    output logic [1:0]       res_count
);

    localparam logic [POS_W-1:0] POS_MAX = '1;

    logic [7:0]       c;
    char_class_t      cl;
    ctx_t             begin_ctx;
    ctx_t             c_ctx;
    logic [POS_W-1:0] c_start;
    logic [POS_W-1:0] c_len;
    logic [POS_W-1:0] grow_len;
    logic [POS_W-1:0] emit_len;
    logic             emit_a;
    logic             emit_b;
    logic             start_new;
    logic             is_exp;
    token_t           rec_a;
    token_t           rec_b;

    always_comb begin
        c        = din.char_code;
        cl       = classify(c);
        grow_len = (open_len != POS_MAX) ? open_len + 1'b1 : open_len;
        is_exp   = (c == CH_E_LOWER) || (c == CH_E_UPPER) ||
                   (c == CH_P_LOWER) || (c == CH_P_UPPER);

        case (cl)
            CL_LETTER: begin
                begin_ctx = CTX_IDENT;
            end
            CL_DIGIT: begin
                begin_ctx = CTX_NUM;
            end
            CL_PUNCT: begin
                if (c == CH_DQUOTE) begin
                    begin_ctx = CTX_STR;
                end else if (c == CH_SQUOTE) begin
                    begin_ctx = CTX_CHR;
                end else begin
                    begin_ctx = CTX_PUNCT;
                end
            end
            default: begin
                begin_ctx = CTX_NONE;
            end
        endcase

        c_ctx     = ctx;
        c_start   = open_start;
        c_len     = open_len;
        emit_a    = 1'b0;
        emit_len  = open_len;
        start_new = 1'b0;

        case (ctx)
            CTX_IDENT: begin
                if (cl == CL_LETTER || cl == CL_DIGIT) begin
                    c_len = grow_len;
                end else begin
                    emit_a    = 1'b1;
                    start_new = 1'b1;
                end
            end
            CTX_PUNCT: begin
                if (cl == CL_PUNCT && c != CH_DQUOTE && c != CH_SQUOTE) begin
                    c_len = grow_len;
                end else begin
                    emit_a    = 1'b1;
                    start_new = 1'b1;
                end
            end
            CTX_NUM: begin
                if (cl == CL_LETTER || cl == CL_DIGIT) begin
                    c_len = grow_len;
                    if (is_exp) begin
                        c_ctx = CTX_EXP;
                    end
                end else if (c == CH_SQUOTE || c == CH_DOT) begin
                    c_len = grow_len;
                end else begin
                    emit_a    = 1'b1;
                    start_new = 1'b1;
                end
            end
            CTX_EXP: begin
                if (cl == CL_DIGIT || c == CH_PLUS || c == CH_MINUS) begin
                    c_len = grow_len;
                    c_ctx = CTX_NUM;
                end else begin
                    emit_a    = 1'b1;
                    start_new = 1'b1;
                end
            end
            CTX_STR, CTX_CHR: begin
                c_len = grow_len;
                if ((ctx == CTX_STR && c == CH_DQUOTE) ||
                    (ctx == CTX_CHR && c == CH_SQUOTE)) begin
                    emit_a   = 1'b1;
                    emit_len = grow_len;
                    c_ctx    = CTX_NONE;
                    c_len    = '0;
                end else if (c == CH_BACKSLASH) begin
                    c_ctx = (ctx == CTX_STR) ? CTX_STR_ESC : CTX_CHR_ESC;
                end
            end
            CTX_STR_ESC: begin
                c_len = grow_len;
                c_ctx = CTX_STR;
            end
            CTX_CHR_ESC: begin
                c_len = grow_len;
                c_ctx = CTX_CHR;
            end
            default: begin
                start_new = 1'b1;
            end
        endcase

        if (start_new) begin
            c_ctx = begin_ctx;
            if (begin_ctx != CTX_NONE) begin
                c_start = pos;
                c_len   = {{(POS_W-1){1'b0}}, 1'b1};
            end else if (emit_a) begin
                c_len = '0;
            end
        end

        emit_b = din.end_of_name && (c_ctx != CTX_NONE);

        rec_a = '{token_kind:   kind_of(ctx),
                  token_start:  TOKEN_W'(open_start),
                  token_length: TOKEN_W'(emit_len),
                  last_in_run:  !emit_b};
        rec_b = '{token_kind:   kind_of(c_ctx),
                  token_start:  TOKEN_W'(c_start),
                  token_length: TOKEN_W'(c_len),
                  last_in_run:  1'b1};

        if (emit_a) begin
            res0 = rec_a;
        end else begin
            res0 = rec_b;
        end
        res1      = rec_b;
        res_count = {1'b0, emit_a} + {1'b0, emit_b};

        if (din.end_of_name) begin
            ctx_next   = CTX_NONE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
        end else begin
            ctx_next   = c_ctx;
            pos_next   = (pos != POS_MAX) ? pos + 1'b1 : pos;
            start_next = c_start;
            len_next   = c_len;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ctl_fifo.sv =====
`default_nettype none

module ctl_fifo
    import ctl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_count,
    input  token_t     push0,
    input  token_t     push1,
    input  logic       pop,
    output token_t     head,
    output logic       not_empty,
    output logic       room_for_two
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);

    token_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_p1;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign wr_ptr_p1    = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push_count);
    assign rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next   = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    assign head         = mem_reg[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= DEPTH_CNT - CNT_W'(2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push1;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("Result queue count exceeds its depth.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count != 2'd0) |-> (count_reg <= DEPTH_CNT - CNT_W'(2)))
        else $error("Results were pushed without room for two entries.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("Result queue popped while empty.");

endmodule

`default_nettype wire

// ===== rtl/c_token_lexer.sv =====
`default_nettype none

// Splits a character stream into C-style tokens, one character per beat on the s_ channel,
// and returns each finished token (kind, start, length) as one beat on the m_ channel. The
// lexer state updates in the cycle a character is accepted, so a new character can be taken
// every ready cycle; a character that closes one token and completes another at end of name
// yields two result beats, which drain through a four-entry result queue. s_ready is high
// while the queue has room for two results, so throughput is one character per cycle
// whenever the consumer keeps up. Positions and lengths saturate at 2^POSITION_BITS - 1.

module c_token_lexer
    import ctl_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  lex_in_t s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output token_t  m_data
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    ctx_t                     ctx_reg;
    ctx_t                     ctx_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] start_reg;
    logic [POSITION_BITS-1:0] start_next;
    logic [POSITION_BITS-1:0] len_reg;
    logic [POSITION_BITS-1:0] len_next;
    token_t                   res0;
    token_t                   res1;
    logic [1:0]               res_count;
    logic [1:0]               push_count;
    logic                     s_fire;
    logic                     m_fire;

    assign s_fire     = s_valid && s_ready;
    assign m_fire     = m_valid && m_ready;
    assign push_count = s_fire ? res_count : 2'd0;

    ctl_step #(
        .POS_W(POSITION_BITS)
    ) u_step (
        .ctx       (ctx_reg),
        .pos       (pos_reg),
        .open_start(start_reg),
        .open_len  (len_reg),
        .din       (s_data),
        .ctx_next  (ctx_next),
        .pos_next  (pos_next),
        .start_next(start_next),
        .len_next  (len_next),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    ctl_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_count  (push_count),
        .push0       (res0),
        .push1       (res1),
        .pop         (m_fire),
        .head        (m_data),
        .not_empty   (m_valid),
        .room_for_two(s_ready)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg   <= CTX_NONE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
        end else if (s_fire) begin
            ctx_reg   <= ctx_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(ctx_reg))
        else $error("Lexer context is not one-hot.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.end_of_name) |=> (pos_reg == '0 && ctx_reg == CTX_NONE))
        else $error("End of name did not return the lexer to its reset state.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_data.end_of_name && pos_reg != POS_MAX)
            |=> (pos_reg == $past(pos_reg) + 1'b1))
        else $error("Character position did not advance.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && ctx_reg == CTX_NONE) |-> (res_count <= 2'd1))
        else $error("Two results produced while no token was open.");

endmodule

`default_nettype wire
